// File: sv/sha_pkg.sv
`timescale 1ns / 1ps
package sha_pkg;

  localparam int unsigned QueueDepth = 2;

  typedef enum logic [1:0] {
    CMD_DATA,
    CMD_FINAL
  } cmd_e;

  // command handed from the front to the back
  typedef struct packed {
    cmd_e        cmd;
    logic [31:0] word;
    logic [2:0]  nbytes;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_ROUND,
    ST_ADD,
    ST_EMIT
  } back_state_e;

  localparam logic [31:0] InitHash [8] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
  };

  localparam logic [31:0] RoundKey [64] = '{
    32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
    32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
    32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
    32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
    32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
    32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
    32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
    32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
    32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
    32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
    32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
    32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
    32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
    32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
    32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
    32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
  };

  function automatic logic [31:0] ror(input logic [31:0] x, input int unsigned r);
    ror = (x >> r) | (x << (32 - r));
  endfunction

endpackage

// File: sv/sha_front.sv
`timescale 1ns / 1ps
module sha_front #(
  parameter int unsigned Depth = sha_pkg::QueueDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  output logic          full,
  input  logic [31:0]   word_data_i,
  input  logic [2:0]    byte_count_i,
  input  logic          last_i,
  output logic          cmd_valid_o,
  output sha_pkg::cmd_t cmd_o,
  input  logic          cmd_take_i
);
  import sha_pkg::*;

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  cmd_t          mem_q [Depth];
  logic [AW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [AW:0]   cnt_q, cnt_d;
  cmd_t          cmd_new;
  logic          wr_en, rd_en;

  // classify: clamp byte count, mask unused bytes of a final word
  always_comb begin
    cmd_new.cmd    = last_i ? CMD_FINAL : CMD_DATA;
    cmd_new.nbytes = (byte_count_i > 3'd4) ? 3'd4 : byte_count_i;
    cmd_new.word   = word_data_i;
    if (last_i) begin
      case (cmd_new.nbytes)
        3'd0:    cmd_new.word = 32'h0;
        3'd1:    cmd_new.word = word_data_i & 32'hFF00_0000;
        3'd2:    cmd_new.word = word_data_i & 32'hFFFF_0000;
        3'd3:    cmd_new.word = word_data_i & 32'hFFFF_FF00;
        default: cmd_new.word = word_data_i;
      endcase
    end
  end

  assign full        = (cnt_q == (AW+1)'(Depth));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = mem_q[rd_q];
  assign wr_en       = push_i && !full;
  assign rd_en       = cmd_take_i && cmd_valid_o;

  always_comb begin
    wr_d  = wr_en ? ((wr_q == AW'(Depth - 1)) ? '0 : wr_q + 1'b1) : wr_q;
    rd_d  = rd_en ? ((rd_q == AW'(Depth - 1)) ? '0 : rd_q + 1'b1) : rd_q;
    cnt_d = cnt_q + (AW+1)'(wr_en) - (AW+1)'(rd_en);
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_q] <= cmd_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end
endmodule

// File: sv/sha_back.sv
`timescale 1ns / 1ps
module sha_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  input  sha_pkg::cmd_t cmd_i,
  output logic          cmd_take_o,
  output logic          empty,
  input  logic          pop_i,
  output logic [63:0]   digest_part_o,
  output logic [1:0]    part_index_o,
  output logic          part_last_o
);
  import sha_pkg::*;

  back_state_e state_q, state_d;
  logic [31:0] hash_q [8];
  logic [31:0] win_q [16];
  logic [31:0] v_q [8];
  logic [3:0]  pos_q;
  logic [63:0] len_q;
  logic [5:0]  rnd_q;
  logic [1:0]  part_q;
  // padding progress of a final command
  logic        final_q, pad_done_q, fin_after_q;

  logic        load_en, round_en, add_en, emit_pop;
  logic [31:0] load_word;
  logic [63:0] len_next;
  logic [31:0] wt, s0, s1, e1, ch, a0, mj, t1, t2;

  assign empty         = (state_q != ST_EMIT);
  assign digest_part_o = {hash_q[{part_q, 1'b0}], hash_q[{part_q, 1'b1}]};
  assign part_index_o  = part_q;
  assign part_last_o   = (part_q == 2'd3);
  assign emit_pop      = (state_q == ST_EMIT) && pop_i;

  // word to store this cycle while loading
  always_comb begin
    load_word = 32'h0;
    len_next  = len_q;
    if (!final_q) begin
      if (cmd_i.cmd == CMD_FINAL) begin
        len_next = len_q + {58'h0, cmd_i.nbytes, 3'b000};
        case (cmd_i.nbytes)
          3'd0:    load_word = 32'h8000_0000;
          3'd1:    load_word = cmd_i.word | 32'h0080_0000;
          3'd2:    load_word = cmd_i.word | 32'h0000_8000;
          3'd3:    load_word = cmd_i.word | 32'h0000_0080;
          default: load_word = cmd_i.word;
        endcase
      end else begin
        len_next  = len_q + 64'd32;
        load_word = cmd_i.word;
      end
    end else if (!pad_done_q) begin
      load_word = 32'h8000_0000;
    end else if (pos_q == 4'd14 && fin_after_q) begin
      load_word = len_q[63:32];
    end else if (pos_q == 4'd15 && fin_after_q) begin
      load_word = len_q[31:0];
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_take_o = 1'b0;
    load_en    = 1'b0;
    round_en   = 1'b0;
    add_en     = 1'b0;
    case (state_q)
      ST_LOAD: begin
        if (final_q || cmd_valid_i) begin
          load_en    = 1'b1;
          cmd_take_o = !final_q;
          if (pos_q == 4'd15) begin
            state_d = ST_ROUND;
          end
        end
      end
      ST_ROUND: begin
        round_en = 1'b1;
        if (rnd_q == 6'd63) begin
          state_d = ST_ADD;
        end
      end
      ST_ADD: begin
        add_en  = 1'b1;
        state_d = (final_q && fin_after_q) ? ST_EMIT : ST_LOAD;
      end
      ST_EMIT: begin
        if (pop_i && part_q == 2'd3) begin
          state_d = ST_LOAD;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  // schedule and round
  always_comb begin
    s0 = ror(win_q[1], 7) ^ ror(win_q[1], 18) ^ (win_q[1] >> 3);
    s1 = ror(win_q[14], 17) ^ ror(win_q[14], 19) ^ (win_q[14] >> 10);
    wt = win_q[0];
    e1 = ror(v_q[4], 6) ^ ror(v_q[4], 11) ^ ror(v_q[4], 25);
    ch = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
    t1 = v_q[7] + e1 + ch + RoundKey[rnd_q] + wt;
    a0 = ror(v_q[0], 2) ^ ror(v_q[0], 13) ^ ror(v_q[0], 22);
    mj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
    t2 = a0 + mj;
  end

  // datapath: window shifts, word 0 is the current schedule word
  always_ff @(posedge clk_i) begin
    if (load_en) begin
      win_q[pos_q] <= load_word;
      if (pos_q == 4'd15) begin
        for (int j = 0; j < 8; j++) v_q[j] <= hash_q[j];
      end
    end
    if (round_en) begin
      for (int j = 0; j < 15; j++) win_q[j] <= win_q[j+1];
      win_q[15] <= win_q[0] + s0 + win_q[9] + s1;
      for (int j = 1; j < 8; j++) v_q[j] <= v_q[j-1];
      v_q[4] <= v_q[3] + t1;
      v_q[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      for (int j = 0; j < 8; j++) hash_q[j] <= InitHash[j];
      pos_q       <= '0;
      len_q       <= '0;
      rnd_q       <= '0;
      part_q      <= '0;
      final_q     <= 1'b0;
      pad_done_q  <= 1'b0;
      fin_after_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_en) begin
        pos_q <= pos_q + 4'd1;
        if (!final_q) begin
          len_q <= len_next;
          if (cmd_i.cmd == CMD_FINAL) begin
            final_q    <= 1'b1;
            pad_done_q <= (cmd_i.nbytes != 3'd4);
            // length fits after the pad word in this block
            fin_after_q <= (cmd_i.nbytes != 3'd4) && (pos_q < 4'd14);
          end
        end else if (!pad_done_q) begin
          pad_done_q  <= 1'b1;
          fin_after_q <= (pos_q < 4'd14);
        end
      end
      if (round_en) begin
        rnd_q <= rnd_q + 6'd1;
      end
      if (add_en) begin
        for (int j = 0; j < 8; j++) hash_q[j] <= hash_q[j] + v_q[j];
        // a block ended without room for the length: next block carries it
        if (final_q && pad_done_q) begin
          fin_after_q <= 1'b1;
        end
      end
      if (emit_pop) begin
        part_q <= part_q + 2'd1;
        if (part_q == 2'd3) begin
          for (int j = 0; j < 8; j++) hash_q[j] <= InitHash[j];
          len_q       <= '0;
          final_q     <= 1'b0;
          pad_done_q  <= 1'b0;
          fin_after_q <= 1'b0;
        end
      end
    end
  end
endmodule

// File: sv/sha256_hash.sv
`timescale 1ns / 1ps
// sha-256 with standard padding; four 64-bit digest transactions per message
// a 2-entry command queue separates the input side from the single round unit
// a block stores 16 words, then runs 64 rounds and one add; the queue takes words meanwhile until full
// last word: padding stores and one or two compressions; the first digest transaction
// follows the final add, then one per pop
// reset (async, active low) restores the initial hash and clears length/queue
module sha256_hash #(
  parameter int unsigned QueueDepth = sha_pkg::QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [31:0] word_data_i,
  input  logic [2:0]  byte_count_i,
  input  logic        last_i,
  output logic        empty,
  input  logic        pop,
  output logic [63:0] digest_part_o,
  output logic [1:0]  part_index_o,
  output logic        part_last_o
);
  import sha_pkg::*;

  // command queue between front and back
  logic cmd_valid, cmd_take;
  cmd_t cmd;

  sha_front #(.Depth(QueueDepth)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full        (full),
    .word_data_i (word_data_i),
    .byte_count_i(byte_count_i),
    .last_i      (last_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_take_i  (cmd_take)
  );

  // compression engine, padding sequencer and digest output
  sha_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (cmd_valid),
    .cmd_i        (cmd),
    .cmd_take_o   (cmd_take),
    .empty        (empty),
    .pop_i        (pop),
    .digest_part_o(digest_part_o),
    .part_index_o (part_index_o),
    .part_last_o  (part_last_o)
  );
endmodule
